>>> sv/olids_pkg.sv
// ----------------------------------------------------------------------------
// olids_pkg - shared types for the ordered list store
// Operation codes, status codes and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package olids_pkg;

   localparam int OLIDS_CAPACITY = 16;

   typedef enum logic [2:0] {
      F_INS_FIRST  = 3'd0,
      F_INS_LAST   = 3'd1,
      F_INS_BEFORE = 3'd2,
      F_INS_AFTER  = 3'd3,
      F_DELETE     = 3'd4,
      F_SEARCH     = 3'd5,
      F_READ       = 3'd6
   } func_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic     cmp_en;
      logic     upd_en;
      func_type op;
   } cell_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic signed [31:0] val;
      logic               prior;   // a match exists in a lower cell
      logic               first;   // this cell holds the first match
      logic               carry;   // a match exists in this or a lower cell
   } cell_link_type;

endpackage

>>> sv/olids_cell.sv
// ----------------------------------------------------------------------------
// olids_cell - one entry of the ordered list
// Holds one value, compares it with the key, and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module olids_cell
   import olids_pkg::*;
#(
   parameter int CAPACITY = OLIDS_CAPACITY,
   parameter int INDEX    = 0
) (
   input  logic                                  clock,
   input  cell_ctrl_type                         ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]         len,
   input  logic signed [31:0]                    key,
   input  logic signed [31:0]                    new_value,
   input  cell_link_type                         left,
   input  logic signed [31:0]                    right_val,
   output cell_link_type                         link
);

   localparam int LEN_W = $clog2(CAPACITY + 1);

   logic signed [31:0] val_ff, val_in;
   logic               match_ff, match_in;
   logic               prior, first, carry;

   assign prior  = left.carry;
   assign first  = match_ff & ~prior;
   assign carry  = prior | match_ff;

   assign link.val    = val_ff;
   assign link.prior  = prior;
   assign link.first  = first;
   assign link.carry  = carry;

   assign match_in = ctrl.cmp_en ? ((val_ff == key) && (LEN_W'(INDEX) < len)) : match_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.upd_en) begin
         case (ctrl.op)
            F_INS_FIRST: begin
               val_in = (INDEX == 0) ? new_value : left.val;
            end
            F_INS_LAST: begin
               if (LEN_W'(INDEX) == len) val_in = new_value;
            end
            F_INS_BEFORE: begin
               if (first) val_in = new_value;
               else if (prior) val_in = left.val;
            end
            F_INS_AFTER: begin
               if (left.first) val_in = new_value;
               else if (left.prior) val_in = left.val;
            end
            F_DELETE: begin
               if (carry) val_in = right_val;
            end
            default: val_in = val_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      match_ff <= match_in;
   end

endmodule

>>> sv/ordered_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search - ordered list with insert/delete/search
// Keeps up to CAPACITY signed 32-bit entries in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one operation per beat (insert first/last/before/after,
//   delete, search, indexed read). rsp_ returns one beat per request with
//   the status, the read data and the list length after the operation.
//   Timing: the edge that accepts a request registers the key compare in
//   every cell; the execute state then resolves the first match along the
//   chain, shifts the cells and loads the response register, and rsp_tvalid
//   rises with that load. A new request is not accepted until the previous
//   one has executed.
//   The response register is the only wait point: while rsp_tready is low
//   a finished result holds, the next request is still accepted and its
//   execute cycle waits until the response register frees up.
//   Reset empties the list (length zero); entry contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_search
   import olids_pkg::*;
#(
   parameter int CAPACITY = OLIDS_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // func[2:0], key[34:3], new_value[66:35], position[70:67]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], read_data[33:2], length[38:34]
);

   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int RD_N  = (CAPACITY < 16) ? CAPACITY : 16;
   localparam int CMP_W = (LEN_W > 4) ? LEN_W : 4;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   func_type           func_ff;
   logic signed [31:0] nv_ff;
   logic [3:0]         pos_ff;
   logic signed [31:0] rd_ff, rd_in;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff, status;
   logic signed [31:0] rsp_data_ff, data;
   logic [4:0]         rsp_len_ff;

   logic               req_fire, exec_go, upd_ok, found, full, rd_ok;
   cell_ctrl_type      ctrl;
   cell_link_type      links [CAPACITY];
   cell_link_type      lefts [CAPACITY];
   logic signed [31:0] rights [CAPACITY];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign exec_go    = (state_ff == S_EXEC) & (~rsp_valid_ff | rsp_tready);

   assign ctrl.cmp_en = req_fire;
   assign ctrl.upd_en = exec_go & upd_ok;
   assign ctrl.op     = func_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_left_edge
         assign lefts[i] = '0;
      end else begin : g_left
         assign lefts[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_right_edge
         assign rights[i] = '0;
      end else begin : g_right
         assign rights[i] = links[i+1].val;
      end
      olids_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .len       (len_ff),
         .key       (req_tdata[34:3]),
         .new_value (nv_ff),
         .left      (lefts[i]),
         .right_val (rights[i]),
         .link      (links[i])
      );
   end

   always_comb begin
      rd_in = '0;
      for (int k = 0; k < RD_N; k++) begin
         if (req_tdata[70:67] == 4'(k)) rd_in = links[k].val;
      end
   end

   assign found = links[CAPACITY-1].carry;
   assign full  = (len_ff == LEN_W'(CAPACITY));
   assign rd_ok = (CMP_W'(pos_ff) < CMP_W'(len_ff));

   always_comb begin
      status = ST_OK;
      data   = '0;
      upd_ok = 1'b0;
      len_in = len_ff;
      unique case (func_ff) inside
         F_INS_FIRST, F_INS_LAST: begin
            if (full) status = ST_FULL;
            else upd_ok = 1'b1;
         end
         F_INS_BEFORE, F_INS_AFTER: begin
            if (full) status = ST_FULL;
            else if (!found) status = ST_NOT_FOUND;
            else upd_ok = 1'b1;
         end
         F_DELETE: begin
            if (!found) status = ST_NOT_FOUND;
            else upd_ok = 1'b1;
         end
         F_SEARCH: begin
            if (!found) status = ST_NOT_FOUND;
         end
         F_READ: begin
            if (rd_ok) data = rd_ff;
            else status = ST_RANGE;
         end
         default: status = ST_OK;
      endcase
      if (upd_ok) begin
         if (func_ff == F_DELETE) len_in = len_ff - LEN_W'(1);
         else len_in = len_ff + LEN_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) state_in = S_EXEC;
         S_EXEC: if (exec_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            len_ff       <= len_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= func_type'(req_tdata[2:0]);
         nv_ff   <= req_tdata[66:35];
         pos_ff  <= req_tdata[70:67];
         rd_ff   <= rd_in;
      end
      if (exec_go) begin
         rsp_status_ff <= status;
         rsp_data_ff   <= data;
         rsp_len_ff    <= 5'(len_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff, rsp_data_ff, rsp_status_ff};

endmodule
